@@ src/ctce_pkg.sv @@
// shared types and constants for the text console character engine
package ctce_pkg;

   localparam int MAX_ADDR_W = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BLANK = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] ATTR_DEFAULT = 8'h07;

   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [7:0]            ch;
      logic [MAX_ADDR_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_pos;
      logic        cursor_written;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } result_type;

endpackage

@@ src/ctce_front.sv @@
// front stage: decodes a request into a command and holds it for the queue
module ctce_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_kind,
   input  logic [7:0]       in_char,
   input  logic [4:0]       in_row,
   input  logic [6:0]       in_col,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ctce_pkg::cmd_type cmd
);
   import ctce_pkg::*;

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic [31:0] rd_addr;
   logic        rd_inside;

   assign rd_addr = 32'(in_row) * 32'(COLUMNS) + 32'(in_col);
   assign rd_inside = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));

   assign in_ready = !vld_ff || cmd_ready;
   assign cmd_valid = vld_ff;
   assign cmd = cmd_ff;

   always_comb begin
      cmd_in = cmd_ff;
      vld_in = vld_ff;
      if (vld_ff && cmd_ready) vld_in = 1'b0;
      if (in_valid && in_ready) begin
         vld_in = 1'b1;
         cmd_in.ch = in_char;
         cmd_in.addr = rd_addr[MAX_ADDR_W-1:0];
         unique case (kind_type'(in_kind))
            REQ_PUT: begin
               if (in_char == CH_NUL) cmd_in.op = OP_NOP;
               else if (in_char == CH_NEWLINE) cmd_in.op = OP_NEWLINE;
               else if (in_char == CH_BACKSPACE) cmd_in.op = OP_BACKSPACE;
               else cmd_in.op = OP_PUT;
            end
            REQ_CLEAR: cmd_in.op = OP_CLEAR;
            REQ_READ: cmd_in.op = rd_inside ? OP_READ : OP_NOP;
            default: cmd_in.op = OP_NOP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

endmodule

@@ src/ctce_queue.sv @@
// short command queue between the front and back stages
module ctce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ctce_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ctce_pkg::cmd_type pop_cmd
);
   import ctce_pkg::*;

   cmd_type slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = slots_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_cmd;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/ctce_back.sv @@
// back stage: screen memory, cursor, scroll and clear sequencer, result register
module ctce_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  ctce_pkg::cmd_type    cmd,
   output logic                 res_valid,
   input  logic                 res_ready,
   output ctce_pkg::result_type res
);
   import ctce_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK
   } state_type;

   state_type state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   logic rvld_ff, rvld_in;
   logic rwr_ff, rwr_in;
   logic [7:0] rch_ff, rch_in, rattr_ff, rattr_in;

   logic [7:0] mem [CELLS];
   logic [7:0] rdata_ff;
   logic we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0] wdata;
   logic [31:0] nl_pos, src_addr, w_row, w_col, w_pos;

   assign nl_pos = 32'(pos_ff) + 32'(COLUMNS) - 32'(col_ff);
   assign src_addr = 32'(cnt_ff) + 32'(COLUMNS);
   assign cmd_ready = (state_ff == ST_IDLE) && !rvld_ff;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      rvld_in = rvld_ff;
      rwr_in = rwr_ff;
      rch_in = rch_ff;
      rattr_in = rattr_ff;
      we = 1'b0;
      waddr = pos_ff;
      wdata = CH_BLANK;
      raddr = cnt_ff;
      if (rvld_ff && res_ready) rvld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               rvld_in = 1'b1;
               rwr_in = 1'b1;
               rch_in = 8'h00;
               rattr_in = 8'h00;
               unique case (cmd.op) inside
                  OP_NOP: rwr_in = 1'b0;
                  OP_READ: begin
                     rvld_in = 1'b0;
                     raddr = cmd.addr[ADDR_W-1:0];
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     rvld_in = 1'b0;
                     row_in = '0;
                     col_in = '0;
                     pos_in = '0;
                     cnt_in = '0;
                     pend_in = 1'b1;
                     state_in = ST_BLANK;
                  end
                  OP_BACKSPACE: begin
                     if (col_ff == '0 && row_ff == '0) begin
                        rwr_in = 1'b0;
                     end else begin
                        we = 1'b1;
                        waddr = pos_ff - 1'b1;
                        pos_in = pos_ff - 1'b1;
                        if (col_ff == '0) begin
                           col_in = COL_W'(COLUMNS - 1);
                           row_in = row_ff - 1'b1;
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                  end
                  OP_PUT, OP_NEWLINE: begin
                     if (cmd.op == OP_PUT) begin
                        we = 1'b1;
                        wdata = cmd.ch;
                     end
                     if (cmd.op == OP_PUT && col_ff != COL_W'(COLUMNS - 1)) begin
                        col_in = col_ff + 1'b1;
                        pos_in = pos_ff + 1'b1;
                     end else if (row_ff == ROW_W'(ROWS - 1)) begin
                        // bottom row: scroll the grid up one line
                        rvld_in = 1'b0;
                        col_in = '0;
                        pos_in = ADDR_W'((ROWS - 1) * COLUMNS);
                        cnt_in = '0;
                        state_in = ST_SCROLL_RD;
                     end else begin
                        row_in = row_ff + 1'b1;
                        col_in = '0;
                        pos_in = nl_pos[ADDR_W-1:0];
                     end
                  end
                  default: rwr_in = 1'b0;
               endcase
            end
         end
         ST_READ: begin
            rvld_in = 1'b1;
            rwr_in = 1'b0;
            rch_in = rdata_ff;
            rattr_in = ATTR_DEFAULT;
            state_in = ST_IDLE;
         end
         ST_SCROLL_RD: begin
            raddr = src_addr[ADDR_W-1:0];
            state_in = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            we = 1'b1;
            waddr = cnt_ff;
            wdata = rdata_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELLS - COLUMNS - 1)) begin
               pend_in = 1'b1;
               state_in = ST_BLANK;
            end else begin
               state_in = ST_SCROLL_RD;
            end
         end
         ST_BLANK: begin
            we = 1'b1;
            waddr = cnt_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
               pend_in = 1'b0;
               if (pend_ff) begin
                  rvld_in = 1'b1;
                  rwr_in = 1'b1;
                  rch_in = 8'h00;
                  rattr_in = 8'h00;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      rwr_ff <= rwr_in;
      rch_ff <= rch_in;
      rattr_ff <= rattr_in;
      if (reset) begin
         state_ff <= ST_BLANK;
         row_ff <= '0;
         col_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         rvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         rvld_ff <= rvld_in;
      end
   end

   assign w_row = 32'(row_ff);
   assign w_col = 32'(col_ff);
   assign w_pos = 32'(pos_ff);
   assign res_valid = rvld_ff;
   assign res.cursor_row = w_row[4:0];
   assign res.cursor_col = w_col[6:0];
   assign res.cursor_pos = w_pos[10:0];
   assign res.cursor_written = rwr_ff;
   assign res.cell_char = rch_ff;
   assign res.cell_attr = rattr_ff;

endmodule

@@ src/text_console_char_engine_unit.sv @@
// top level of the text console character engine
//
// usage
// - req channel: one request per handshake; req_tuser carries the request kind
//   (put character, clear screen, read one cell), req_tdata the byte and the
//   cell coordinates for reads
// - rsp channel: exactly one result per request, in request order, giving the
//   cursor after the request, whether the cursor port was updated and the
//   read cell (char and attribute, zero unless a valid read)
// - the back stage handles one request at a time and takes the next only once
//   the result of the last one has been taken
// - a scroll copies the grid up one cell at a time through the screen memory,
//   reading in ST_SCROLL_RD and writing in ST_SCROLL_WR, then blanks the last row;
//   a clear sweeps all ROWS*COLUMNS cells, one per cycle
// - reset: the screen memory is blanked by a sweep over all ROWS*COLUMNS cells;
//   requests are taken into the front stage and queue meanwhile, results start
//   after the sweep
// - a stalled rsp side holds its result; the queue keeps taking requests until
//   it and the front stage are full
module text_console_char_engine_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // req_type
   input  logic [23:0] req_tdata,  // char_code, read_row, read_col, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_row, cursor_col, cursor_pos, cursor_written, cell_char, cell_attr
   output logic [39:0] rsp_tdata
);
   import ctce_pkg::*;

   // front to queue
   logic    f_valid, f_ready;
   cmd_type f_cmd;
   // queue to back
   logic    q_valid, q_ready;
   cmd_type q_cmd;
   // back result
   result_type res;

   ctce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_kind(req_tuser),
      .in_char(req_tdata[7:0]),
      .in_row(req_tdata[12:8]),
      .in_col(req_tdata[19:13]),
      .cmd_valid(f_valid),
      .cmd_ready(f_ready),
      .cmd(f_cmd)
   );

   ctce_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_cmd(f_cmd),
      .pop_valid(q_valid),
      .pop_ready(q_ready),
      .pop_cmd(q_cmd)
   );

   ctce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(q_valid),
      .cmd_ready(q_ready),
      .cmd(q_cmd),
      .res_valid(rsp_tvalid),
      .res_ready(rsp_tready),
      .res(res)
   );

   // pack the result, first field in the low bits
   assign rsp_tdata = {res.cell_attr, res.cell_char, res.cursor_written,
                       res.cursor_pos, res.cursor_col, res.cursor_row};

   // linear cursor position matches row and column for the default geometry range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(res.cursor_pos) ==
         ((32'(res.cursor_row) * 32'(COLUMNS) + 32'(res.cursor_col)) & 32'h7FF)))
      else $error("cursor position out of step with row and column");

   // a read result always carries the default attribute
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.cell_attr != 8'h00) |->
         (res.cell_attr == ATTR_DEFAULT && !res.cursor_written))
      else $error("read result with bad attribute or cursor flag");

   // the back stage only takes a command while no result is pending
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !rsp_tvalid)
      else $error("command taken while a result waits");

   // a command taken into the queue shows up as queue valid in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (f_valid && f_ready) |=> q_valid)
      else $error("queue lost a command");

endmodule
